>>> sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define DTTF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define DTTF_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/dttf_pkg.sv
package dttf_pkg;

   // default configuration
   localparam int DEF_MAX_FRACTION_DIGITS = 9;
   localparam int DEF_INTEGER_BITS        = 15;
   localparam int DEF_FRACTION_BITS       = 16;

   // character codes
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // where the parser stands within the string
   typedef enum logic [2:0] {
      PH_LEAD,
      PH_INT,
      PH_FRAC,
      PH_SKIP_OK,
      PH_SKIP_BAD
   } phase_type;

   // control sequence of the top level
   typedef enum logic [1:0] {
      CTL_PARSE,
      CTL_DIV,
      CTL_SUM,
      CTL_OUT
   } ctl_state_type;

   // divider status toward the control sequence
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // powers of ten, used as a constant table
   function automatic logic [63:0] pow10(input int unsigned n);
      logic [63:0] p;
      case (n)
         0: p = 64'd1;
         1: p = 64'd10;
         2: p = 64'd100;
         3: p = 64'd1000;
         4: p = 64'd10000;
         5: p = 64'd100000;
         6: p = 64'd1000000;
         7: p = 64'd10000000;
         8: p = 64'd100000000;
         9: p = 64'd1000000000;
         default: p = 64'd1000000000;
      endcase
      return p;
   endfunction

endpackage

>>> sv/decimal_text_to_fixed_parser.sv
// Decimal text to signed fixed-point parser.
// Input channel req_: one character per transfer on req_char_code. Ordinary
// characters are taken one per cycle while req_ready is high; a zero byte ends the string.
// Result channel rsp_: one transfer per string, carrying rsp_valid_res,
// rsp_value (two's complement, FRACTION_BITS fractional bits, low 32 bits)
// and rsp_overflow.
// Sequence: after the zero byte is taken, the fraction is divided by the power
// of ten of its digit count in a restoring divider that yields one quotient
// bit per cycle, FRACTION_BITS + 1 bits in all; then the magnitude register is
// loaded, and the result register is loaded once no earlier result is held or
// it is being taken. Until then req_ready is low; the next string is taken
// from the cycle after the result register is loaded.
// The result waits in an output register, so characters of the next string
// are taken while rsp_ready is low. If a second string ends while the first
// result is still held, the block waits with req_ready low until it is taken.
// Reset (synchronous, active high) clears the parser to the leading
// whitespace phase and drops any pending result.
module decimal_text_to_fixed_parser
   import dttf_pkg::*;
#(
   parameter int MAX_FRACTION_DIGITS = DEF_MAX_FRACTION_DIGITS,
   parameter int INTEGER_BITS        = DEF_INTEGER_BITS,
   parameter int FRACTION_BITS       = DEF_FRACTION_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_code,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_valid_res,
   output logic signed [31:0] rsp_value,
   output logic               rsp_overflow
);

   localparam int FRAC_W = $clog2(pow10(MAX_FRACTION_DIGITS));
   localparam int DEN_W  = $clog2(pow10(MAX_FRACTION_DIGITS) + 64'd1);
   localparam int CNT_W  = $clog2(MAX_FRACTION_DIGITS + 1);
   localparam int QUO_W  = FRACTION_BITS + 1;
   localparam int MAG_W  = INTEGER_BITS + FRACTION_BITS + 1;
   localparam int ACC_W  = INTEGER_BITS + 4;
   localparam logic [63:0] SAT_POS = (64'd1 << (INTEGER_BITS + FRACTION_BITS)) - 64'd1;
   localparam logic [63:0] SAT_NEG = 64'd0 - (SAT_POS + 64'd1);

   ctl_state_type             state_ff, state_in;
   phase_type                 phase_ff, phase_in;
   logic                      neg_ff, neg_in;
   logic [INTEGER_BITS-1:0]   int_ff, int_in;
   logic [FRAC_W-1:0]         frac_ff, frac_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      sat_ff, sat_in;
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic                      movf_ff, movf_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_res_ff;
   logic [31:0]               rsp_value_ff;
   logic                      rsp_overflow_ff;

   logic                      div_start;
   logic                      load_rsp;
   div_status_type            div_status;
   logic [QUO_W-1:0]          quotient;
   logic [DEN_W-1:0]          denom;

   logic [7:0]                char_diff;
   logic [3:0]                digit;
   logic                      is_digit;
   logic                      is_space;
   logic [ACC_W-1:0]          int_next;
   logic [FRAC_W+3:0]         frac_next;
   logic [QUO_W:0]            quo_round;
   logic [63:0]               mag_ext;
   logic [31:0]               mag_low;
   logic [31:0]               signed_low;

   // character classes and digit value
   always_comb begin
      char_diff = req_char_code - CHAR_ZERO;
      digit     = char_diff[3:0];
      is_digit  = req_char_code inside {[CHAR_ZERO:CHAR_NINE]};
      is_space  = req_char_code inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
      int_next  = (ACC_W'(int_ff) << 3) + (ACC_W'(int_ff) << 1) + ACC_W'(digit);
      frac_next = ((FRAC_W + 4)'(frac_ff) << 3) + ((FRAC_W + 4)'(frac_ff) << 1)
                  + (FRAC_W + 4)'(digit);
   end

   // fraction rounding and magnitude
   always_comb begin
      quo_round = {1'b0, quotient} + (QUO_W + 1)'(1);
      mag_in    = {1'b0, int_ff, {FRACTION_BITS{1'b0}}}
                  + MAG_W'(quo_round[QUO_W:1]);
      movf_in   = sat_ff || mag_in[MAG_W-1];
      mag_ext   = 64'(mag_ff);
      mag_low   = mag_ext[31:0];
      signed_low = neg_ff ? (32'd0 - mag_low) : mag_low;
      denom     = DEN_W'(pow10(32'(cnt_ff)));
   end

   // control sequence and parser next state
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      int_in    = int_ff;
      frac_in   = frac_ff;
      cnt_in    = cnt_ff;
      sat_in    = sat_ff;
      req_ready = 1'b0;
      div_start = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         CTL_PARSE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_char_code == CHAR_NUL) begin
                  div_start = 1'b1;
                  state_in  = CTL_DIV;
               end else begin
                  case (phase_ff)
                     PH_LEAD: begin
                        if (is_space) begin
                           phase_in = PH_LEAD;
                        end else if (req_char_code == CHAR_MINUS) begin
                           neg_in   = 1'b1;
                           phase_in = PH_INT;
                        end else if (req_char_code == CHAR_PLUS) begin
                           phase_in = PH_INT;
                        end else if (is_digit) begin
                           phase_in = PH_INT;
                           if (int_next > ACC_W'({INTEGER_BITS{1'b1}})) begin
                              int_in = '1;
                              sat_in = 1'b1;
                           end else begin
                              int_in = int_next[INTEGER_BITS-1:0];
                           end
                        end else if (req_char_code == CHAR_DOT) begin
                           phase_in = PH_FRAC;
                        end else begin
                           phase_in = PH_SKIP_OK;
                        end
                     end
                     PH_INT: begin
                        if (is_digit) begin
                           if (int_next > ACC_W'({INTEGER_BITS{1'b1}})) begin
                              int_in = '1;
                              sat_in = 1'b1;
                           end else begin
                              int_in = int_next[INTEGER_BITS-1:0];
                           end
                        end else if (req_char_code == CHAR_DOT) begin
                           phase_in = PH_FRAC;
                        end else begin
                           phase_in = PH_SKIP_OK;
                        end
                     end
                     PH_FRAC: begin
                        if (is_digit) begin
                           if (cnt_ff < CNT_W'(MAX_FRACTION_DIGITS)) begin
                              frac_in = frac_next[FRAC_W-1:0];
                              cnt_in  = cnt_ff + CNT_W'(1);
                           end
                        end else begin
                           phase_in = PH_SKIP_BAD;
                        end
                     end
                     PH_SKIP_OK, PH_SKIP_BAD: begin
                        phase_in = phase_ff;
                     end
                     default: begin
                        phase_in = PH_SKIP_BAD;
                     end
                  endcase
               end
            end
         end
         CTL_DIV: begin
            if (div_status.done) begin
               state_in = CTL_SUM;
            end
         end
         CTL_SUM: begin
            state_in = CTL_OUT;
         end
         CTL_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = CTL_PARSE;
               phase_in = PH_LEAD;
               neg_in   = 1'b0;
               int_in   = '0;
               frac_in  = '0;
               cnt_in   = '0;
               sat_in   = 1'b0;
            end
         end
         default: begin
            state_in = CTL_PARSE;
         end
      endcase
   end

   // state and parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_PARSE;
         phase_ff <= PH_LEAD;
         neg_ff   <= 1'b0;
         int_ff   <= '0;
         frac_ff  <= '0;
         cnt_ff   <= '0;
         sat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         int_ff   <= int_in;
         frac_ff  <= frac_in;
         cnt_ff   <= cnt_in;
         sat_ff   <= sat_in;
      end
   end

   // magnitude register
   always_ff @(posedge clock) begin
      if (state_ff == CTL_SUM) begin
         mag_ff  <= mag_in;
         movf_ff <= movf_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         if (phase_ff == PH_SKIP_BAD) begin
            rsp_valid_res_ff <= 1'b0;
            rsp_value_ff     <= '0;
            rsp_overflow_ff  <= 1'b0;
         end else if (movf_ff) begin
            rsp_valid_res_ff <= 1'b1;
            rsp_value_ff     <= neg_ff ? SAT_NEG[31:0] : SAT_POS[31:0];
            rsp_overflow_ff  <= 1'b1;
         end else begin
            rsp_valid_res_ff <= 1'b1;
            rsp_value_ff     <= signed_low;
            rsp_overflow_ff  <= 1'b0;
         end
      end
   end

   // fraction divider
   dttf_div #(
      .DEN_W (DEN_W),
      .QUO_W (QUO_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (DEN_W'(frac_ff)),
      .denom    (denom),
      .status   (div_status),
      .quotient (quotient)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_valid_res_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_overflow  = rsp_overflow_ff;

endmodule

>>> sv/dttf_div.sv
// restoring divider, one quotient bit per cycle
// numerator must be below the denominator; quotient is numer * 2^QUO_W / denom
module dttf_div
   import dttf_pkg::*;
#(
   parameter int DEN_W = 30,
   parameter int QUO_W = 17
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DEN_W-1:0]     numer,
   input  logic [DEN_W-1:0]     denom,
   output div_status_type       status,
   output logic [QUO_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   rem_dbl;
   logic [DEN_W:0]   rem_sub;
   logic             fits;

   // one shift, compare and subtract step
   always_comb begin
      rem_dbl = {rem_ff, 1'b0};
      rem_sub = rem_dbl - {1'b0, den_ff};
      fits    = rem_dbl >= {1'b0, den_ff};
      rem_in  = fits ? rem_sub[DEN_W-1:0] : rem_dbl[DEN_W-1:0];
      quo_in  = {quo_ff[QUO_W-2:0], fits};
      cnt_in  = cnt_ff - CNT_W'(1);
   end

   // iteration counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_W'(QUO_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_in;
      end
   end

   // remainder and quotient shift registers
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= numer;
         den_ff <= denom;
         quo_ff <= '0;
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign status.busy = cnt_ff != '0;
   assign status.done = cnt_ff == CNT_W'(1);
   assign quotient    = quo_ff;

endmodule

>>> sv/dttf_checker.sv
`include "assert_macros.svh"

// port-level checks of the parser
module dttf_checker
   import dttf_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [7:0]         req_char_code,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_valid_res,
   input logic signed [31:0] rsp_value,
   input logic               rsp_overflow
);

   // a stalled result holds
   `DTTF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_valid_res) && $stable(rsp_overflow), "stalled result changed")

   // reset drops any pending result
   `DTTF_ASSERT_NR(a_rsp_reset, clock, reset |=> !rsp_valid, "result valid after reset")

   // a rejected string carries a zero value and no overflow
   `DTTF_ASSERT(a_bad_zero, clock, reset, rsp_valid && !rsp_valid_res |-> rsp_value == 32'sd0 && !rsp_overflow, "rejected string with nonzero fields")

   // end of string stops input while the fraction is divided
   `DTTF_ASSERT(a_eos_stall, clock, reset, req_valid && req_ready && req_char_code == CHAR_NUL |=> !req_ready, "input taken right after end of string")

endmodule

bind decimal_text_to_fixed_parser dttf_checker u_checker (.*);
